@@ rtl/core/dwsp_pkg.sv @@
// Package for the two-wheel speed loop: field widths, command and
// register index codes, and gain reset values.
// No dependencies.
`default_nettype none

package dwsp_pkg;

   // Field and datapath widths fixed by the item format.
   localparam int GAIN_W      = 16;
   localparam int COUNT_W     = 16;
   localparam int SETPOINT_W  = 16;
   localparam int DRIVE_W     = 16;
   localparam int SPEED_W     = 24;
   localparam int ERR_W       = 24;
   localparam int FRAC_SHIFT  = 12;
   localparam int SPEED_SHIFT = 4;
   localparam int CSR_INDEX_W = 3;

   // Wheel lanes.
   localparam int NUM_WHEELS  = 2;
   localparam int WHEEL_LEFT  = 0;
   localparam int WHEEL_RIGHT = 1;

   // Item commands.
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   // Gain register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEFT_PROP      = 3'd0,
      CSR_LEFT_INTEGRAL  = 3'd1,
      CSR_LEFT_DERIV     = 3'd2,
      CSR_RIGHT_PROP     = 3'd3,
      CSR_RIGHT_INTEGRAL = 3'd4,
      CSR_RIGHT_DERIV    = 3'd5
   } csr_index_type;

   // Gain reset values, signed Q8.8.
   localparam logic signed [GAIN_W-1:0] LEFT_PROP_RESET      = 16'sd25600;
   localparam logic signed [GAIN_W-1:0] LEFT_INTEGRAL_RESET  = 16'sd2560;
   localparam logic signed [GAIN_W-1:0] LEFT_DERIV_RESET     = 16'sd0;
   localparam logic signed [GAIN_W-1:0] RIGHT_PROP_RESET     = 16'sd26880;
   localparam logic signed [GAIN_W-1:0] RIGHT_INTEGRAL_RESET = 16'sd2688;
   localparam logic signed [GAIN_W-1:0] RIGHT_DERIV_RESET    = 16'sd0;

endpackage

`default_nettype wire

@@ rtl/core/dual_wheel_speed_pid.sv @@
// Two-wheel encoder velocity loop with one fixed-point PID per wheel.
// Depends on dwsp_pkg for widths, command codes and gain reset values.
//
//   Channel  Direction  Handshake                 Beat contents
//   req_     in         req_valid / req_ready     cmd, encoder counts, setpoints
//   rsp_     out        rsp_valid / rsp_ready     left and right drive values
//   csr_     in         csr_write_enable          gain index and value
//
// One beat is taken every cycle while the output side keeps pace.
// A control tick passes five registers on its way to the result: input register,
// errors and state update, gain products, product sum, then the truncating and
// saturating output register. A sample beat leaves the input register in the
// cycle after acceptance, when it updates the speed sums.
// Reset clears the speed and error state and loads the default gains.
// A stalled result holds the full stages behind it; ready is formed across all
// stages in the same cycle, so gaps between beats close up without delay.
`default_nettype none

module dual_wheel_speed_pid #(
   parameter int NEG_WRAP_LIMIT = 30000,
   parameter int ERROR_SUM_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_cmd,
   input  wire logic        [dwsp_pkg::COUNT_W-1:0]    req_left_encoder_count,
   input  wire logic        [dwsp_pkg::COUNT_W-1:0]    req_right_encoder_count,
   input  wire logic signed [dwsp_pkg::SETPOINT_W-1:0] req_left_setpoint,
   input  wire logic signed [dwsp_pkg::SETPOINT_W-1:0] req_right_setpoint,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [dwsp_pkg::DRIVE_W-1:0]    rsp_left_drive,
   output logic signed      [dwsp_pkg::DRIVE_W-1:0]    rsp_right_drive,
   input  wire logic                                   csr_write_enable,
   input  wire logic        [dwsp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [dwsp_pkg::GAIN_W-1:0]     csr_write_data
);

   localparam int NW         = dwsp_pkg::NUM_WHEELS;
   localparam int GAIN_W     = dwsp_pkg::GAIN_W;
   localparam int COUNT_W    = dwsp_pkg::COUNT_W;
   localparam int SPEED_W    = dwsp_pkg::SPEED_W;
   localparam int ERR_W      = dwsp_pkg::ERR_W;
   localparam int DRIVE_W    = dwsp_pkg::DRIVE_W;
   localparam int ESUM_W     = ERROR_SUM_BITS;
   localparam int ESUM_ADD_W = ((ESUM_W > ERR_W) ? ESUM_W : ERR_W) + 1;
   localparam int DIFF_W     = SPEED_W + dwsp_pkg::SPEED_SHIFT + 1;
   localparam int DERR_W     = ERR_W + 1;
   localparam int PROD_P_W   = GAIN_W + ERR_W;
   localparam int PROD_I_W   = GAIN_W + ESUM_W;
   localparam int PROD_D_W   = GAIN_W + DERR_W;
   localparam int ACC_W      = ((PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W) + 2;
   localparam int QUO_W      = ACC_W - dwsp_pkg::FRAC_SHIFT;

   // Gain registers.
   logic signed [GAIN_W-1:0] gain_p_ff [NW];
   logic signed [GAIN_W-1:0] gain_i_ff [NW];
   logic signed [GAIN_W-1:0] gain_d_ff [NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff[dwsp_pkg::WHEEL_LEFT]  <= dwsp_pkg::LEFT_PROP_RESET;
         gain_i_ff[dwsp_pkg::WHEEL_LEFT]  <= dwsp_pkg::LEFT_INTEGRAL_RESET;
         gain_d_ff[dwsp_pkg::WHEEL_LEFT]  <= dwsp_pkg::LEFT_DERIV_RESET;
         gain_p_ff[dwsp_pkg::WHEEL_RIGHT] <= dwsp_pkg::RIGHT_PROP_RESET;
         gain_i_ff[dwsp_pkg::WHEEL_RIGHT] <= dwsp_pkg::RIGHT_INTEGRAL_RESET;
         gain_d_ff[dwsp_pkg::WHEEL_RIGHT] <= dwsp_pkg::RIGHT_DERIV_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dwsp_pkg::CSR_LEFT_PROP:      gain_p_ff[dwsp_pkg::WHEEL_LEFT]  <= csr_write_data;
            dwsp_pkg::CSR_LEFT_INTEGRAL:  gain_i_ff[dwsp_pkg::WHEEL_LEFT]  <= csr_write_data;
            dwsp_pkg::CSR_LEFT_DERIV:     gain_d_ff[dwsp_pkg::WHEEL_LEFT]  <= csr_write_data;
            dwsp_pkg::CSR_RIGHT_PROP:     gain_p_ff[dwsp_pkg::WHEEL_RIGHT] <= csr_write_data;
            dwsp_pkg::CSR_RIGHT_INTEGRAL: gain_i_ff[dwsp_pkg::WHEEL_RIGHT] <= csr_write_data;
            dwsp_pkg::CSR_RIGHT_DERIV:    gain_d_ff[dwsp_pkg::WHEEL_RIGHT] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Stage valids and flow control.
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, rsp_vld_ff;
   logic a_vld_in, b_vld_in, c_vld_in, d_vld_in, rsp_vld_in;
   logic a_move, b_move, c_move, d_move;
   logic b_free, c_free, d_free, out_free;
   logic req_fire, a_is_tick;
   dwsp_pkg::cmd_type a_cmd_ff, a_cmd_in;

   always_comb begin
      req_fire  = req_valid && req_ready;
      a_is_tick = (a_cmd_ff == dwsp_pkg::CMD_TICK);
      out_free  = !rsp_vld_ff || rsp_ready;
      d_move    = d_vld_ff && out_free;
      d_free    = !d_vld_ff || out_free;
      c_move    = c_vld_ff && d_free;
      c_free    = !c_vld_ff || d_free;
      b_move    = b_vld_ff && c_free;
      b_free    = !b_vld_ff || c_free;
      a_move    = a_vld_ff && (!a_is_tick || b_free);
      req_ready = !a_vld_ff || a_move;

      a_vld_in   = req_fire || (a_vld_ff && !a_move);
      b_vld_in   = (a_move && a_is_tick) || (b_vld_ff && !b_move);
      c_vld_in   = b_move || (c_vld_ff && !c_move);
      d_vld_in   = c_move || (d_vld_ff && !d_move);
      rsp_vld_in = d_move || (rsp_vld_ff && !rsp_ready);
      a_cmd_in   = dwsp_pkg::cmd_type'(req_cmd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         c_vld_ff   <= c_vld_in;
         d_vld_ff   <= d_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_cmd_ff <= a_cmd_in;
      end
   end

   // Per-wheel payload registers.
   logic        [COUNT_W-1:0]             a_count_ff    [NW];
   logic signed [dwsp_pkg::SETPOINT_W-1:0] a_setpoint_ff [NW];
   logic signed [DRIVE_W-1:0]             drive_ff      [NW];
   logic        [COUNT_W-1:0]             a_count_in    [NW];
   logic signed [dwsp_pkg::SETPOINT_W-1:0] a_setpoint_in [NW];

   always_comb begin
      a_count_in[dwsp_pkg::WHEEL_LEFT]     = req_left_encoder_count;
      a_count_in[dwsp_pkg::WHEEL_RIGHT]    = req_right_encoder_count;
      a_setpoint_in[dwsp_pkg::WHEEL_LEFT]  = req_left_setpoint;
      a_setpoint_in[dwsp_pkg::WHEEL_RIGHT] = req_right_setpoint;
   end

   for (genvar g = 0; g < NW; g++) begin : g_wheel
      logic signed [SPEED_W-1:0]  speed_ff, speed_in;
      logic signed [ESUM_W-1:0]   esum_ff, esum_in;
      logic signed [ERR_W-1:0]    prev_ff, prev_in;
      logic signed [ERR_W-1:0]    b_err_ff, b_err_in;
      logic signed [ESUM_W-1:0]   b_esum_ff;
      logic signed [DERR_W-1:0]   b_derr_ff, b_derr_in;
      logic signed [PROD_P_W-1:0] c_prod_p_ff, c_prod_p_in;
      logic signed [PROD_I_W-1:0] c_prod_i_ff, c_prod_i_in;
      logic signed [PROD_D_W-1:0] c_prod_d_ff, c_prod_d_in;
      logic signed [ACC_W-1:0]    d_acc_ff, d_acc_in;
      logic signed [DRIVE_W-1:0]  drive_in;

      logic signed [COUNT_W:0]     cnt_val;
      logic signed [SPEED_W:0]     spd_sum;
      logic signed [SPEED_W-1:0]   spd_sat;
      logic signed [DIFF_W-1:0]    err_diff;
      logic        [DIFF_W-ERR_W:0] err_top;
      logic signed [ESUM_ADD_W-1:0] esum_add;
      logic        [ESUM_ADD_W-ESUM_W:0] esum_top;
      logic signed [ESUM_W-1:0]    esum_sat;
      logic signed [QUO_W-1:0]     quo_floor;
      logic signed [QUO_W-1:0]     quo;
      logic                        round_up;
      logic        [QUO_W-DRIVE_W:0] quo_top;

      // Speed accumulation and PID error terms from the input register.
      always_comb begin
         if (a_count_ff[g] > COUNT_W'(NEG_WRAP_LIMIT)) begin
            cnt_val = $signed({1'b1, a_count_ff[g]});
         end else begin
            cnt_val = $signed({1'b0, a_count_ff[g]});
         end
         // The right encoder is mounted mirrored, so its count is negated.
         if (g == dwsp_pkg::WHEEL_RIGHT) begin
            spd_sum = (SPEED_W+1)'(speed_ff) - (SPEED_W+1)'(cnt_val);
         end else begin
            spd_sum = (SPEED_W+1)'(speed_ff) + (SPEED_W+1)'(cnt_val);
         end
         if (spd_sum[SPEED_W] != spd_sum[SPEED_W-1]) begin
            spd_sat = {spd_sum[SPEED_W], {(SPEED_W-1){~spd_sum[SPEED_W]}}};
         end else begin
            spd_sat = spd_sum[SPEED_W-1:0];
         end

         // Error in Q.4: setpoint minus the accumulated count moved to Q.4.
         err_diff = DIFF_W'(a_setpoint_ff[g])
                  - (DIFF_W'(speed_ff) <<< dwsp_pkg::SPEED_SHIFT);
         err_top  = err_diff[DIFF_W-1:ERR_W-1];
         if ((&err_top) || !(|err_top)) begin
            b_err_in = err_diff[ERR_W-1:0];
         end else begin
            b_err_in = {err_diff[DIFF_W-1], {(ERR_W-1){~err_diff[DIFF_W-1]}}};
         end

         esum_add = ESUM_ADD_W'(esum_ff) + ESUM_ADD_W'(b_err_in);
         esum_top = esum_add[ESUM_ADD_W-1:ESUM_W-1];
         if ((&esum_top) || !(|esum_top)) begin
            esum_sat = esum_add[ESUM_W-1:0];
         end else begin
            esum_sat = {esum_add[ESUM_ADD_W-1], {(ESUM_W-1){~esum_add[ESUM_ADD_W-1]}}};
         end

         b_derr_in = DERR_W'(b_err_in) - DERR_W'(prev_ff);

         // Next state: a sample accumulates, a tick updates the PID and clears speed.
         speed_in = speed_ff;
         esum_in  = esum_ff;
         prev_in  = prev_ff;
         if (a_move) begin
            if (a_is_tick) begin
               speed_in = '0;
               esum_in  = esum_sat;
               prev_in  = b_err_in;
            end else begin
               speed_in = spd_sat;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            speed_ff <= '0;
            esum_ff  <= '0;
            prev_ff  <= '0;
         end else begin
            speed_ff <= speed_in;
            esum_ff  <= esum_in;
            prev_ff  <= prev_in;
         end
      end

      // Gain products, their sum, and the scaled and saturated drive.
      always_comb begin
         c_prod_p_in = gain_p_ff[g] * b_err_ff;
         c_prod_i_in = gain_i_ff[g] * b_esum_ff;
         c_prod_d_in = gain_d_ff[g] * b_derr_ff;
         d_acc_in    = ACC_W'(c_prod_p_ff) + ACC_W'(c_prod_i_ff) + ACC_W'(c_prod_d_ff);

         // Truncate toward zero: a negative sum with a fraction rounds up by one.
         quo_floor = d_acc_ff[ACC_W-1:dwsp_pkg::FRAC_SHIFT];
         round_up  = d_acc_ff[ACC_W-1] && (|d_acc_ff[dwsp_pkg::FRAC_SHIFT-1:0]);
         quo       = quo_floor + $signed({{(QUO_W-1){1'b0}}, round_up});
         quo_top   = quo[QUO_W-1:DRIVE_W-1];
         if ((&quo_top) || !(|quo_top)) begin
            drive_in = quo[DRIVE_W-1:0];
         end else begin
            drive_in = {quo[QUO_W-1], {(DRIVE_W-1){~quo[QUO_W-1]}}};
         end
      end

      always_ff @(posedge clock) begin
         if (req_fire) begin
            a_count_ff[g]    <= a_count_in[g];
            a_setpoint_ff[g] <= a_setpoint_in[g];
         end
         if (a_move && a_is_tick) begin
            b_err_ff  <= b_err_in;
            b_esum_ff <= esum_sat;
            b_derr_ff <= b_derr_in;
         end
         if (b_move) begin
            c_prod_p_ff <= c_prod_p_in;
            c_prod_i_ff <= c_prod_i_in;
            c_prod_d_ff <= c_prod_d_in;
         end
         if (c_move) begin
            d_acc_ff <= d_acc_in;
         end
         if (d_move) begin
            drive_ff[g] <= drive_in;
         end
      end
   end

   // Result beat.
   assign rsp_valid       = rsp_vld_ff;
   assign rsp_left_drive  = drive_ff[dwsp_pkg::WHEEL_LEFT];
   assign rsp_right_drive = drive_ff[dwsp_pkg::WHEEL_RIGHT];

endmodule

`default_nettype wire
